[rtl/core/jsu_pkg.sv]
// Shared types and constants for the JSON string unescape block.
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int MAX_RES    = 5;
    localparam int CNT_W      = $clog2(MAX_RES + 1);
    localparam int HEX_DIGITS = 3;
    localparam int HS_W       = $clog2(HEX_DIGITS + 1);
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = QPTR_W + 1;

    localparam logic [7:0]  CH_U       = 8'h75;
    localparam logic [7:0]  CH_QUOTE   = 8'h22;
    localparam logic [7:0]  CH_BSLASH  = 8'h5C;
    localparam logic [7:0]  LATIN1_MAX = 8'hFF;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_PLAIN = 2'd1,
        MODE_ESC   = 2'd2,
        MODE_HEX   = 2'd3
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       body_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       string_last;
        logic       closed_by_quote;
    } out_item_t;

    // One decoded item: up to MAX_RES bytes to emit in order.
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [CNT_W-1:0]        cnt;
        logic                    is_data;
        logic                    ending;
        logic                    quoted;
    } job_t;

endpackage

[rtl/core/json_string_unescape.sv]
// Path: an accepted item's job is written into the job queue, then each result into the output register.
// Throughput: one item per cycle while each item yields at most one result and results are popped;
// an item that yields n results (up to 5) holds the serializer until all n are loaded, and a
// 4-entry job queue absorbs the burst so input keeps flowing until the queue is full.
// Reset (async, active low): scanner idle, job queue and output register empty.
`timescale 1ns / 1ps

module json_string_unescape
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    logic accept;
    logic job_valid;
    job_t job;
    job_t head;
    logic head_valid;
    logic head_done;

    assign accept = push && !full;

    jsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .job_valid (job_valid),
        .job       (job)
    );

    jsu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (job_valid),
        .wr_data   (job),
        .rd_en     (head_done),
        .rd_data   (head),
        .full      (full),
        .not_empty (head_valid)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_done  (head_done),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

[rtl/core/jsu_front.sv]
// Front end: accepts body bytes, runs the escape scanner and builds result jobs.
`timescale 1ns / 1ps

module jsu_front
    import jsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    output logic     job_valid,
    output job_t     job
);

    scan_mode_t       mode_reg, mode_next, mode_cur;
    logic [HS_W-1:0]  hs_reg, hs_next, hs_cur;
    logic [15:0]      hv_reg, hv_next, hv_cur;
    logic [7:0]       hex_digits_reg [HEX_DIGITS];

    logic [7:0]       c;
    logic             fin;
    logic             hex_ok;
    logic [3:0]       hex_nib;
    logic             active;
    logic             do_plain;
    logic             flush;
    logic             tail_v;
    logic [7:0]       tail;
    logic             ending;
    logic             quoted;
    logic             dig_we;
    logic [CNT_W-1:0] cnt;

    function automatic logic [4:0] hex_of(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
            r = {1'b1, 4'(ch - 8'h30)};
        else if (ch >= 8'h61 && ch <= 8'h66)
            r = {1'b1, 4'(ch - 8'h57)};
        else if (ch >= 8'h41 && ch <= 8'h46)
            r = {1'b1, 4'(ch - 8'h37)};
        return r;
    endfunction

    function automatic logic [7:0] escape_map(input logic [7:0] ch);
        logic [7:0] r;
        unique case (ch)
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            default: r = ch;
        endcase
        return r;
    endfunction

    assign c   = item.data_byte;
    assign fin = item.body_end;
    assign {hex_ok, hex_nib} = hex_of(c);

    always_comb
    begin
        mode_cur  = item.first_byte ? MODE_PLAIN : mode_reg;
        hs_cur    = item.first_byte ? '0 : hs_reg;
        hv_cur    = item.first_byte ? '0 : hv_reg;
        mode_next = mode_cur;
        hs_next   = hs_cur;
        hv_next   = hv_cur;
        active    = 1'b1;
        do_plain  = 1'b0;
        flush     = 1'b0;
        tail_v    = 1'b0;
        tail      = c;
        ending    = 1'b0;
        quoted    = 1'b0;
        dig_we    = 1'b0;

        unique case (mode_cur)
            MODE_IDLE:
            begin
                active = 1'b0;
            end
            MODE_PLAIN:
            begin
                do_plain = 1'b1;
            end
            MODE_ESC:
            begin
                if (c == CH_U)
                begin
                    if (fin)
                        tail_v = 1'b1;
                    else
                    begin
                        mode_next = MODE_HEX;
                        hs_next   = '0;
                        hv_next   = '0;
                    end
                end
                else
                begin
                    tail_v    = 1'b1;
                    tail      = escape_map(c);
                    mode_next = MODE_PLAIN;
                end
            end
            MODE_HEX:
            begin
                if (!hex_ok)
                begin
                    // bad digit: replay 'u' and the digits, then treat byte as plain
                    flush     = 1'b1;
                    mode_next = MODE_PLAIN;
                    hs_next   = '0;
                    do_plain  = 1'b1;
                end
                else
                begin
                    hv_next = {hv_cur[11:0], hex_nib};
                    if (hs_cur == HS_W'(HEX_DIGITS))
                    begin
                        if (hv_next[15:8] == 8'h00)
                        begin
                            tail_v = 1'b1;
                            tail   = hv_next[7:0] & LATIN1_MAX;
                        end
                        mode_next = MODE_PLAIN;
                        hs_next   = '0;
                    end
                    else if (fin)
                    begin
                        flush   = 1'b1;
                        tail_v  = 1'b1;
                        hs_next = '0;
                    end
                    else
                    begin
                        dig_we  = 1'b1;
                        hs_next = hs_cur + HS_W'(1);
                    end
                end
            end
            default:
            begin
                active = 1'b0;
            end
        endcase

        if (do_plain)
        begin
            priority if (c == CH_QUOTE)
            begin
                ending    = 1'b1;
                quoted    = 1'b1;
                mode_next = MODE_IDLE;
            end
            else if (c == CH_BSLASH)
            begin
                if (fin)
                    tail_v = 1'b1;
                else
                    mode_next = MODE_ESC;
            end
            else
                tail_v = 1'b1;
        end

        if (active && fin)
        begin
            ending    = 1'b1;
            mode_next = MODE_IDLE;
            hs_next   = '0;
        end

        cnt = (flush ? CNT_W'(hs_cur) + CNT_W'(1) : CNT_W'(0)) + CNT_W'(tail_v);

        job.bytes[0] = flush ? CH_U : tail;
        job.bytes[1] = (flush && hs_cur >= HS_W'(1)) ? hex_digits_reg[0] : tail;
        job.bytes[2] = (flush && hs_cur >= HS_W'(2)) ? hex_digits_reg[1] : tail;
        job.bytes[3] = (flush && hs_cur >= HS_W'(3)) ? hex_digits_reg[2] : tail;
        job.bytes[4] = tail;
        job.is_data  = (cnt != '0);
        // nothing to emit on a closing step: send a bare end marker
        job.cnt      = (cnt == '0) ? CNT_W'(1) : cnt;
        job.ending   = ending;
        job.quoted   = quoted;
        job_valid    = accept && active && ((cnt != '0) || ending);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            hs_reg   <= '0;
            hv_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            hs_reg   <= hs_next;
            hv_reg   <= hv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && dig_we)
            hex_digits_reg[hs_cur] <= c;
    end

endmodule

[rtl/core/jsu_queue.sv]
// Job queue between the scanner front end and the result serializer.
`timescale 1ns / 1ps

module jsu_queue
    import jsu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_data,
    input  logic rd_en,
    output job_t rd_data,
    output logic full,
    output logic not_empty
);

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_wr;
    logic              do_rd;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_wr) - QCNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("job queue count out of range");
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("job queue empty but pointers differ");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QCNT_W'(1) && do_rd && !do_wr) |=> (count_reg == '0))
        else $error("job queue failed to drain");
`endif

endmodule

[rtl/core/jsu_back.sv]
// Back end: walks each job's bytes and feeds the result output register.
`timescale 1ns / 1ps

module jsu_back
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  job_t      head,
    output logic      head_done,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg;
    out_item_t        result_reg, result_next;
    logic             load;
    logic             last_elem;

    assign empty     = !out_valid_reg;
    assign result    = result_reg;
    assign load      = head_valid && (!out_valid_reg || pop);
    assign last_elem = (idx_reg == head.cnt - CNT_W'(1));
    assign head_done = load && last_elem;

    always_comb
    begin
        result_next.out_byte        = head.is_data ? head.bytes[idx_reg] : 8'h00;
        result_next.has_byte        = head.is_data;
        result_next.string_last     = head.ending && last_elem;
        result_next.closed_by_quote = head.ending && head.quoted && last_elem;
        idx_next = idx_reg;
        if (load)
            idx_next = last_elem ? '0 : idx_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

`ifndef SYNTH
    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < head.cnt))
        else $error("byte index past end of job");
    a_quote_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.closed_by_quote) |-> result_reg.string_last)
        else $error("quote flag on a non-final result");
    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.has_byte)
            |-> (result_reg.string_last && result_reg.out_byte == 8'h00))
        else $error("malformed end marker");
`endif

endmodule
